// File: hw/rtl/skth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skth_pkg: shared types and constants of the sorted key table
// Sizes, entry layout, status codes, controller states, the structs passed
// between the controller and the histogram, and the value-to-bin mapping.
// ----------------------------------------------------------------------------
package skth_pkg;

    // Table and histogram sizes
    localparam int CAPACITY  = 64;
    localparam int NUM_BINS  = 10;
    localparam int BIN_WIDTH = 100;

    // Field widths of the ports
    localparam int KEY_W     = 27;
    localparam int VAL_W     = 10;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 7;
    localparam int BIN_OUT_W = 4;

    // Internal widths
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int BIN_IDX_W = $clog2(NUM_BINS);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_PROBE_WAIT,
        S_CHECK,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FINISH
    } state_t;

    // One table entry as stored in the entry memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             present;
    } entry_t;

    // Histogram update request
    typedef struct packed {
        logic                 en;
        logic                 dec;
        logic [BIN_IDX_W-1:0] bin;
    } hist_op_t;

    // Entry memory access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // One result as handed to the output register
    typedef struct packed {
        status_t              status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 bin_changed;
        logic [BIN_OUT_W-1:0] bin_index;
        logic [CNT_OUT_W-1:0] bin_count;
    } result_t;

    // Bin of a value: value / BIN_WIDTH, saturated at the last bin
    function automatic logic [BIN_IDX_W-1:0] bin_of(input logic [VAL_W-1:0] value);
        logic [BIN_IDX_W-1:0] b;
        b = '0;
        for (int k = 1; k < NUM_BINS; k++) begin
            if (int'(value) >= k * BIN_WIDTH) begin
                b = BIN_IDX_W'(k);
            end
        end
        return b;
    endfunction

endpackage

// File: hw/rtl/skth_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skth_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module skth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/skth_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skth_hist: value histogram
// Holds one count per bin, applies an increment or a saturating decrement
// and returns the new count of the touched bin in the same cycle.
// ----------------------------------------------------------------------------
module skth_hist (
    input  logic                     clk,
    input  logic                     rst_n,
    input  skth_pkg::hist_op_t       op,
    output logic [skth_pkg::CNT_W-1:0] new_count
);

    logic [skth_pkg::CNT_W-1:0] bins_reg [skth_pkg::NUM_BINS];
    logic [skth_pkg::CNT_W-1:0] cur_count;

    // Read the touched bin and form its new count
    always_comb
    begin
        cur_count = '0;
        if (int'(op.bin) < skth_pkg::NUM_BINS)
        begin
            cur_count = bins_reg[op.bin];
        end
        if (op.dec)
        begin
            new_count = (cur_count != '0) ? cur_count - 1'b1 : cur_count;
        end
        else
        begin
            new_count = cur_count + 1'b1;
        end
    end

    // Clear on reset, write back on update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < skth_pkg::NUM_BINS; i++)
            begin
                bins_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < skth_pkg::NUM_BINS; i++)
            begin
                if (op.en && op.bin == skth_pkg::BIN_IDX_W'(i))
                begin
                    bins_reg[i] <= new_count;
                end
            end
        end
    end

endmodule

// File: hw/rtl/skth_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skth_engine: search and shift controller
// Runs the lower-bound search over the entry memory, resolves the request,
// drives the histogram update and moves entries one per cycle to open or
// close a slot.
// ----------------------------------------------------------------------------
module skth_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_command,
    input  logic [skth_pkg::KEY_W-1:0]    req_key,
    input  logic                          req_has_value,
    input  logic [skth_pkg::VAL_W-1:0]    req_value,
    // entry memory
    output skth_pkg::ram_req_t            ram_req,
    input  skth_pkg::entry_t              ram_rdata,
    // histogram
    output skth_pkg::hist_op_t            hist_op,
    input  logic [skth_pkg::CNT_W-1:0]    hist_count,
    // result side
    input  logic                          slot_free,
    output logic                          res_valid,
    output skth_pkg::result_t             res
);

    skth_pkg::state_t             state_reg, state_next;
    logic                         cmd_reg, cmd_next;
    logic [skth_pkg::KEY_W-1:0]   key_reg, key_next;
    logic                         hasv_reg, hasv_next;
    logic [skth_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [skth_pkg::CNT_W-1:0]   lo_reg, lo_next;
    logic [skth_pkg::CNT_W-1:0]   hi_reg, hi_next;
    logic [skth_pkg::CNT_W-1:0]   mid_reg, mid_next;
    logic [skth_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [skth_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                         wpend_reg, wpend_next;
    logic [skth_pkg::ADDR_W-1:0]  waddr_reg, waddr_next;
    skth_pkg::result_t            res_reg, res_next;

    logic [skth_pkg::CNT_W-1:0]   mid;
    logic [skth_pkg::CNT_W-1:0]   idx_dn;
    logic [skth_pkg::CNT_W-1:0]   idx_up;
    logic                         found;
    skth_pkg::entry_t             new_entry;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dn = idx_reg - 1'b1;
    assign idx_up = idx_reg + 1'b1;
    assign found  = (lo_reg < count_reg) && (ram_rdata.key == key_reg);

    always_comb
    begin
        new_entry.key     = key_reg;
        new_entry.value   = hasv_reg ? val_reg : '0;
        new_entry.present = hasv_reg;
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skth_pkg::S_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        hasv_reg  <= hasv_next;
        val_reg   <= val_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        idx_reg   <= idx_next;
        waddr_reg <= waddr_next;
        res_reg   <= res_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        hasv_next  = hasv_reg;
        val_next   = val_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        wpend_next = wpend_reg;
        waddr_next = waddr_reg;
        res_next   = res_reg;

        req_ready  = 1'b0;
        res_valid  = 1'b0;
        hist_op    = '0;

        // drain a pending shift write, fed straight from the read port
        ram_req.we    = wpend_reg;
        ram_req.waddr = waddr_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = lo_reg[skth_pkg::ADDR_W-1:0];

        res             = res_reg;
        res.entry_count = skth_pkg::CNT_OUT_W'(count_reg);

        unique case (state_reg)
            skth_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next   = req_command;
                    key_next   = req_key;
                    hasv_next  = req_has_value;
                    val_next   = req_value;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = skth_pkg::S_PROBE;
                end
            end

            // issue a probe, or read the lower-bound entry once narrowed
            skth_pkg::S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_req.raddr = mid[skth_pkg::ADDR_W-1:0];
                    mid_next      = mid;
                    state_next    = skth_pkg::S_PROBE_WAIT;
                end
                else
                begin
                    ram_req.raddr = lo_reg[skth_pkg::ADDR_W-1:0];
                    state_next    = skth_pkg::S_CHECK;
                end
            end

            skth_pkg::S_PROBE_WAIT:
            begin
                if (ram_rdata.key < key_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = skth_pkg::S_PROBE;
            end

            // resolve the request and update the histogram
            skth_pkg::S_CHECK:
            begin
                res_next.bin_changed = 1'b0;
                res_next.bin_index   = '0;
                res_next.bin_count   = '0;
                res_next.entry_count = '0;
                if (cmd_reg == skth_pkg::CMD_INSERT)
                begin
                    if (found)
                    begin
                        res_next.status = skth_pkg::ST_DUPLICATE;
                        state_next      = skth_pkg::S_FINISH;
                    end
                    else if (count_reg == skth_pkg::CNT_W'(skth_pkg::CAPACITY))
                    begin
                        res_next.status = skth_pkg::ST_FULL;
                        state_next      = skth_pkg::S_FINISH;
                    end
                    else
                    begin
                        res_next.status = skth_pkg::ST_INSERTED;
                        hist_op.en      = hasv_reg;
                        hist_op.dec     = 1'b0;
                        hist_op.bin     = skth_pkg::bin_of(val_reg);
                        if (hasv_reg)
                        begin
                            res_next.bin_changed = 1'b1;
                            res_next.bin_index   = skth_pkg::BIN_OUT_W'(hist_op.bin);
                            res_next.bin_count   = skth_pkg::CNT_OUT_W'(hist_count);
                        end
                        idx_next   = count_reg;
                        count_next = count_reg + 1'b1;
                        state_next = skth_pkg::S_SHIFT_UP;
                    end
                end
                else
                begin
                    if (!found)
                    begin
                        res_next.status = skth_pkg::ST_NOT_FOUND;
                        state_next      = skth_pkg::S_FINISH;
                    end
                    else
                    begin
                        res_next.status = skth_pkg::ST_DELETED;
                        hist_op.en      = ram_rdata.present;
                        hist_op.dec     = 1'b1;
                        hist_op.bin     = skth_pkg::bin_of(ram_rdata.value);
                        if (ram_rdata.present)
                        begin
                            res_next.bin_changed = 1'b1;
                            res_next.bin_index   = skth_pkg::BIN_OUT_W'(hist_op.bin);
                            res_next.bin_count   = skth_pkg::CNT_OUT_W'(hist_count);
                        end
                        idx_next   = lo_reg;
                        count_next = count_reg - 1'b1;
                        state_next = skth_pkg::S_SHIFT_DN;
                    end
                end
            end

            // move entries up from the top, then store the new entry
            skth_pkg::S_SHIFT_UP:
            begin
                if (idx_reg > lo_reg)
                begin
                    ram_req.raddr = idx_dn[skth_pkg::ADDR_W-1:0];
                    wpend_next    = 1'b1;
                    waddr_next    = idx_reg[skth_pkg::ADDR_W-1:0];
                    idx_next      = idx_dn;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = lo_reg[skth_pkg::ADDR_W-1:0];
                        ram_req.wdata = new_entry;
                        state_next    = skth_pkg::S_FINISH;
                    end
                end
            end

            // move later entries down over the deleted one
            skth_pkg::S_SHIFT_DN:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_req.raddr = idx_up[skth_pkg::ADDR_W-1:0];
                    wpend_next    = 1'b1;
                    waddr_next    = idx_reg[skth_pkg::ADDR_W-1:0];
                    idx_next      = idx_up;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        state_next = skth_pkg::S_FINISH;
                    end
                end
            end

            // hand the result over once the output register is free
            skth_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = skth_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skth_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sorted_key_table_with_histogram.sv
`timescale 1ns / 1ps
// The lower-bound search makes at most 7 probes of the entry memory.
// Requests are handled one at a time: a new one is taken once the result of the
// last has been loaded into the output register. Entries are moved one per cycle
// through the single RAM write port.
// Reset clears the entry count and the histogram; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table_with_histogram: sorted key table with value histogram
// Keeps unique keys in ascending order in one entry memory, inserts and
// deletes by lower-bound search and shifting, and counts values in bins.
// ----------------------------------------------------------------------------
module sorted_key_table_with_histogram (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [skth_pkg::KEY_W-1:0]          entry_key,
    input  logic                                has_value,
    input  logic [skth_pkg::VAL_W-1:0]          entry_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [skth_pkg::STATUS_W-1:0]       status,
    output logic [skth_pkg::CNT_OUT_W-1:0]      entry_count,
    output logic                                bin_changed,
    output logic [skth_pkg::BIN_OUT_W-1:0]      bin_index,
    output logic [skth_pkg::CNT_OUT_W-1:0]      bin_count
);

    skth_pkg::ram_req_t              ram_req;
    skth_pkg::entry_t                ram_rdata;
    skth_pkg::hist_op_t              hist_op;
    logic [skth_pkg::CNT_W-1:0]      hist_count;
    logic                            slot_free;
    logic                            res_valid;
    skth_pkg::result_t               res;

    logic                            out_valid_reg, out_valid_next;
    skth_pkg::result_t               out_res_reg, out_res_next;

    skth_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (in_valid),
        .req_ready     (in_ready),
        .req_command   (command),
        .req_key       (entry_key),
        .req_has_value (has_value),
        .req_value     (entry_value),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .hist_op       (hist_op),
        .hist_count    (hist_count),
        .slot_free     (slot_free),
        .res_valid     (res_valid),
        .res           (res)
    );

    skth_ram #(
        .WIDTH ($bits(skth_pkg::entry_t)),
        .DEPTH (skth_pkg::CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    skth_hist u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (hist_op),
        .new_count (hist_count)
    );

    // Output register: load a finished result, drop it once taken
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign entry_count = out_res_reg.entry_count;
    assign bin_changed = out_res_reg.bin_changed;
    assign bin_index   = out_res_reg.bin_index;
    assign bin_count   = out_res_reg.bin_count;

    // No bin fields without a bin change
    a_no_bin_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bin_changed |-> bin_index == '0 && bin_count == '0)
        else $error("bin fields set without a bin change");

    // Rejected requests never touch the histogram
    a_reject_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == skth_pkg::ST_DUPLICATE || status == skth_pkg::ST_NOT_FOUND
                      || status == skth_pkg::ST_FULL) |-> !bin_changed)
        else $error("rejected request changed a bin");

    // The entry count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(entry_count) <= skth_pkg::CAPACITY)
        else $error("entry count beyond table size");

    // An insert leaves at least one entry
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == skth_pkg::ST_INSERTED |-> entry_count != '0)
        else $error("insert reported an empty table");

endmodule

// File: tb/sorted_key_table_with_histogram_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_with_histogram_tb: self-checking bench for the key table
// Sends insert and delete requests through the input channel and predicts
// each reply from a shadow copy of the sorted table and its value histogram.
// Every reply is compared field by field; most tests add random stalls on both sides.
// ----------------------------------------------------------------------------
module sorted_key_table_with_histogram_tb;
    import skth_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TIME  = 120;
    localparam int MAX_REPORTS  = 10;

    localparam logic [KEY_W-1:0] KEY_TOP      = KEY_W'(99999999);
    localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_ODD_BITS = 27'h5555555;
    localparam logic [KEY_W-1:0] KEY_EVN_BITS = 27'h2AAAAAA;
    localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;
    localparam logic [VAL_W-1:0] VAL_TOP      = VAL_W'(1000);

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 command     = 1'b0;
    logic [KEY_W-1:0]     entry_key   = '0;
    logic                 has_value   = 1'b0;
    logic [VAL_W-1:0]     entry_value = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 bin_changed;
    logic [BIN_OUT_W-1:0] bin_index;
    logic [CNT_OUT_W-1:0] bin_count;

    // Shadow copy of the table and histogram
    logic [KEY_W-1:0] shadow_key [CAPACITY];
    logic [VAL_W-1:0] shadow_val [CAPACITY];
    logic             shadow_has [CAPACITY];
    int               shadow_used = 0;
    int               shadow_bins [NUM_BINS];

    result_t reply_queue [$];

    bit gaps_on      = 1'b1;
    int stall_left   = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int replies_seen = 0;
    int requests     = 0;
    int peak_fill    = 0;
    int status_seen [5];

    sorted_key_table_with_histogram uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .entry_key   (entry_key),
        .has_value   (has_value),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .bin_changed (bin_changed),
        .bin_index   (bin_index),
        .bin_count   (bin_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     CYCLE_LIMIT, reply_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Histogram bin of a value in hundredths, saturated at the last bin
    function automatic int value_bin(input logic [VAL_W-1:0] v);
        int b;
        b = int'(v) / BIN_WIDTH;
        if (b > NUM_BINS - 1)
            b = NUM_BINS - 1;
        return b;
    endfunction

    // Apply one request to the shadow table and return the reply it gives
    function automatic result_t table_update(input command_t cmd,
                                             input logic [KEY_W-1:0] key,
                                             input logic hasv,
                                             input logic [VAL_W-1:0] val);
        result_t r;
        int      pos;
        int      b;
        int      i;
        logic    hit;
        r   = '0;
        pos = 0;
        // lower bound over the sorted keys
        while (pos < shadow_used && shadow_key[pos] < key)
            pos++;
        hit = (pos < shadow_used) && (shadow_key[pos] == key);
        if (cmd == CMD_INSERT)
        begin
            if (hit)
                r.status = ST_DUPLICATE;
            else if (shadow_used >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                // shift later entries up and store the new one
                for (i = shadow_used; i > pos; i--)
                begin
                    shadow_key[i] = shadow_key[i-1];
                    shadow_val[i] = shadow_val[i-1];
                    shadow_has[i] = shadow_has[i-1];
                end
                shadow_key[pos] = key;
                shadow_val[pos] = hasv ? val : '0;
                shadow_has[pos] = hasv;
                shadow_used++;
                r.status = ST_INSERTED;
                if (hasv)
                begin
                    b = value_bin(val);
                    shadow_bins[b]++;
                    r.bin_changed = 1'b1;
                    r.bin_index   = BIN_OUT_W'(b);
                    r.bin_count   = CNT_OUT_W'(shadow_bins[b]);
                end
            end
        end
        else
        begin
            if (!hit)
                r.status = ST_NOT_FOUND;
            else
            begin
                if (shadow_has[pos])
                begin
                    b = value_bin(shadow_val[pos]);
                    if (shadow_bins[b] > 0)
                        shadow_bins[b]--;
                    r.bin_changed = 1'b1;
                    r.bin_index   = BIN_OUT_W'(b);
                    r.bin_count   = CNT_OUT_W'(shadow_bins[b]);
                end
                // close the gap
                for (i = pos; i + 1 < shadow_used; i++)
                begin
                    shadow_key[i] = shadow_key[i+1];
                    shadow_val[i] = shadow_val[i+1];
                    shadow_has[i] = shadow_has[i+1];
                end
                shadow_used--;
                r.status = ST_DELETED;
            end
        end
        r.entry_count = CNT_OUT_W'(shadow_used);
        return r;
    endfunction

    // Key drawn mostly from the legal range, some from a narrow pool, a few full width
    function automatic logic [KEY_W-1:0] fresh_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return KEY_W'($urandom_range(0, 255));
        else if (sel < 20)
            return KEY_W'($urandom);
        else
            return KEY_W'($urandom_range(0, 99999999));
    endfunction

    function automatic logic [KEY_W-1:0] stored_key();
        return shadow_key[$urandom_range(0, shadow_used - 1)];
    endfunction

    // Random value over the full field width
    function automatic logic [VAL_W-1:0] any_value();
        return VAL_W'($urandom_range(0, 1023));
    endfunction

    // Random single bit
    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Send one request, record its predicted reply at acceptance
    task automatic send_request(input command_t cmd, input logic [KEY_W-1:0] key,
                                input logic hasv, input logic [VAL_W-1:0] val);
        result_t want;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        command     = cmd;
        entry_key   = key;
        has_value   = hasv;
        entry_value = val;
        in_valid    = 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        want = table_update(cmd, key, hasv, val);
        reply_queue.push_back(want);
        requests++;
        status_seen[want.status]++;
        if (shadow_used > peak_fill)
            peak_fill = shadow_used;
    endtask

    // Hold off the sender until every predicted reply has come back
    task automatic drain_replies();
        @(negedge clk);
        in_valid = 1'b0;
        while (reply_queue.size() != 0)
            @(negedge clk);
    endtask

    // One random request; shrink sets the share of deletes of stored keys
    task automatic random_request(input int shrink);
        int sel;
        sel = $urandom_range(0, 99);
        if (shadow_used > 0 && sel < 10)
            send_request(CMD_INSERT, stored_key(), any_bit(), any_value());
        else if (shadow_used > 0 && sel < 10 + shrink)
            send_request(CMD_DELETE, stored_key(), any_bit(), any_value());
        else if (sel < 15 + shrink)
            send_request(CMD_DELETE, fresh_key(), any_bit(), any_value());
        else
            send_request(CMD_INSERT, fresh_key(), $urandom_range(0, 3) != 0,
                         any_value());
    endtask

    // Hand back replies with random stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            out_ready  = 1'b0;
            stall_left = $urandom_range(0, 18);
        end
        else
            out_ready = 1'b1;
    end

    // Compare each reply with the oldest prediction
    always @(posedge clk)
    begin : reply_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            replies_seen++;
            if (reply_queue.size() == 0)
                log_mismatch($sformatf("unexpected reply status=%0d count=%0d",
                                       status, entry_count));
            else
            begin
                want = reply_queue.pop_front();
                if (status !== want.status || entry_count !== want.entry_count ||
                    bin_changed !== want.bin_changed || bin_index !== want.bin_index ||
                    bin_count !== want.bin_count)
                    log_mismatch($sformatf(
                        "exp st=%0d cnt=%0d chg=%0b bin=%0d bcnt=%0d, got st=%0d cnt=%0d chg=%0b bin=%0d bcnt=%0d",
                        want.status, want.entry_count, want.bin_changed, want.bin_index,
                        want.bin_count, status, entry_count, bin_changed, bin_index,
                        bin_count));
            end
        end
    end

    // Extremes of the fields and the named corner cases
    task automatic test_directed_cases();
        send_request(CMD_DELETE, '0, 1'b0, '0);                    // delete on empty table
        send_request(CMD_INSERT, '0, 1'b0, VAL_ALL_ONES);          // no value: no bin touched
        send_request(CMD_INSERT, KEY_ALL_ONES, 1'b1, VAL_ALL_ONES); // bin saturates
        send_request(CMD_INSERT, KEY_TOP, 1'b1, VAL_TOP);
        send_request(CMD_INSERT, KEY_ODD_BITS, 1'b1, 10'h155);
        send_request(CMD_INSERT, KEY_EVN_BITS, 1'b1, 10'h2AA);
        send_request(CMD_INSERT, KEY_W'(1), 1'b1, VAL_W'(0));
        send_request(CMD_INSERT, KEY_W'(2), 1'b1, VAL_W'(99));
        send_request(CMD_INSERT, KEY_W'(3), 1'b1, VAL_W'(100));
        send_request(CMD_INSERT, KEY_W'(4), 1'b1, VAL_W'(999));
        send_request(CMD_INSERT, '0, 1'b1, VAL_W'(500));           // duplicate key
        send_request(CMD_INSERT, KEY_ALL_ONES, 1'b0, '0);          // duplicate at the top
        send_request(CMD_DELETE, KEY_W'(2), 1'b0, '0);             // delete with value
        send_request(CMD_DELETE, '0, 1'b1, VAL_ALL_ONES);          // delete without value
        send_request(CMD_DELETE, KEY_W'(5), 1'b0, '0);             // absent key
        send_request(CMD_DELETE, KEY_ALL_ONES, 1'b0, '0);
        send_request(CMD_DELETE, KEY_ODD_BITS, 1'b1, 10'h2AA);
        send_request(CMD_INSERT, KEY_W'(2), 1'b1, VAL_W'(1001));   // above 10.00
        send_request(CMD_DELETE, KEY_TOP, 1'b0, '0);
        send_request(CMD_INSERT, KEY_TOP - 1'b1, 1'b1, VAL_W'(1023));
        send_request(CMD_DELETE, KEY_W'(3), 1'b0, '0);
        send_request(CMD_DELETE, KEY_W'(2), 1'b0, '0);
    endtask

    // Fill to capacity, push against the full table, then empty it again
    task automatic test_full_table();
        while (shadow_used < CAPACITY)
            send_request(CMD_INSERT, fresh_key(), $urandom_range(0, 3) != 0,
                         any_value());
        repeat (4)
            send_request(CMD_INSERT, fresh_key(), 1'b1, any_value());
        repeat (3)
            send_request(CMD_INSERT, stored_key(), 1'b1, any_value());
        send_request(CMD_INSERT, shadow_key[0], 1'b0, '0);
        send_request(CMD_INSERT, shadow_key[CAPACITY-1], 1'b0, '0);
        send_request(CMD_DELETE, shadow_key[CAPACITY-1], 1'b0, '0);
        send_request(CMD_INSERT, KEY_ALL_ONES, 1'b1, VAL_ALL_ONES);
        send_request(CMD_DELETE, shadow_key[0], 1'b0, '0);
        send_request(CMD_INSERT, '0, 1'b1, VAL_W'(0));
        while (shadow_used > 0)
            send_request(CMD_DELETE, stored_key(), 1'b0, '0);
    endtask

    // Alternate growing and shrinking traffic, one segment without stalls
    task automatic test_random_traffic();
        int seg;
        for (seg = 0; seg < 6; seg++)
        begin
            gaps_on = (seg != 3);
            repeat (230)
                random_request((seg % 2 == 0) ? 25 : 62);
            if (seg == 2)
                drain_replies();
        end
        gaps_on = 1'b1;
    endtask

    // Back-to-back traffic with both sides always ready
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (300)
            random_request(40);
    endtask

    initial
    begin
        for (int k = 0; k < NUM_BINS; k++)
            shadow_bins[k] = 0;
        for (int k = 0; k < 5; k++)
            status_seen[k] = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        drain_replies();
        test_full_table();
        drain_replies();
        test_random_traffic();
        test_back_to_back();

        drain_replies();
        repeat (SETTLE_TIME) @(negedge clk);

        $display("%0d requests: %0d inserted, %0d duplicate, %0d deleted, %0d not found, %0d full",
                 requests, status_seen[ST_INSERTED], status_seen[ST_DUPLICATE],
                 status_seen[ST_DELETED], status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        $display("%0d replies checked, peak fill %0d of %0d, %0d mismatches",
                 replies_seen, peak_fill, CAPACITY, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
